// ===== rtl/core/wssf_pkg.sv =====
package wssf_pkg;

    // Default sizes of the line store and of the kernel.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 8;

    // Fixed formats of the interface.
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 16;
    localparam int COORD_W    = 10;
    localparam int POOL_W     = 32;

    // Queue depths between the front part, the back part and the output.
    localparam int MID_DEPTH   = 8;
    localparam int MID_CNT_W   = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    // Reciprocal table for division by a stride of 1 to 15.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_TAB [16] = '{
        21'd1048576, 21'd1048576, 21'd524288, 21'd349526,
        21'd262144,  21'd209716,  21'd174763, 21'd149797,
        21'd131072,  21'd116509,  21'd104858, 21'd95326,
        21'd87382,   21'd80660,   21'd74899,  21'd69906
    };

    // Configuration register indexes.
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STRIDE_X      = 3'd2;
    localparam logic [2:0] REG_STRIDE_Y      = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_PLANE_GAIN    = 3'd6;
    localparam logic [2:0] REG_PLANE_OFFSET  = 3'd7;

    typedef struct packed {
        logic [3:0]         kernel_width;
        logic [3:0]         kernel_height;
        logic [3:0]         stride_x;
        logic [3:0]         stride_y;
        logic [10:0]        image_width;
        logic [10:0]        image_height;
        logic signed [15:0] plane_gain;
        logic signed [31:0] plane_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kernel_width:  4'd2,
        kernel_height: 4'd2,
        stride_x:      4'd2,
        stride_y:      4'd2,
        image_width:   11'd32,
        image_height:  11'd32,
        plane_gain:    16'sd4096,
        plane_offset:  32'sd0
    };

    // One finished result.
    typedef struct packed {
        logic signed [POOL_W-1:0] pooled_value;
        logic [COORD_W-1:0]       out_col;
        logic [COORD_W-1:0]       out_row;
        logic                     plane_done;
    } res_t;

    // A stride of zero acts as a stride of one.
    function automatic logic [3:0] clamp_stride(input logic [3:0] s);
        return (s == 4'd0) ? 4'd1 : s;
    endfunction

endpackage

// ===== rtl/core/window_sum_subsample_forward_unit.sv =====
// Sum pooling with a trainable weight and bias over one plane streamed in
// raster order. One pixel is taken per clock while full is low: the history
// line stores have a bank per kept row, all read and one written at the
// current column in the same cycle, so no pixel waits on another. After the
// edge that accepts the pixel completing its window, a result passes the
// second front stage, the middle queue, two back stages and the output queue
// and waits there until popped; full rises only when the middle and output
// queues back up. Each result is
// bias + floor(weight * window sum / 4096), saturated to 32 bits. Write the
// configuration registers only between transactions, once all results of the
// pixels already pushed have been popped; the line stores need no clearing.
module window_sum_subsample_forward_unit
    import wssf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [PIX_W-1:0]   pixel_value,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [POOL_W-1:0]  pooled_value,
    output logic [COORD_W-1:0]        out_col,
    output logic [COORD_W-1:0]        out_row,
    output logic                      plane_done,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int WS_W  = PIX_W + 2 * $clog2(MAX_KERNEL);
    localparam int MID_W = WS_W + 2 * COORD_W + 1;

    // Configuration registers.
    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KERNEL_WIDTH:  cfg_next.kernel_width  = cfg_data[3:0];
                REG_KERNEL_HEIGHT: cfg_next.kernel_height = cfg_data[3:0];
                REG_STRIDE_X:      cfg_next.stride_x      = cfg_data[3:0];
                REG_STRIDE_Y:      cfg_next.stride_y      = cfg_data[3:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[10:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[10:0];
                REG_PLANE_GAIN:    cfg_next.plane_gain    = cfg_data[15:0];
                REG_PLANE_OFFSET:  cfg_next.plane_offset  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front part: counters, line stores, column window, window selection.
    logic                   mid_push, mid_last, mid_pop, mid_empty;
    logic signed [WS_W-1:0] mid_wsum;
    logic [COORD_W-1:0]     mid_col, mid_row;
    logic [MID_CNT_W-1:0]   mid_count;
    logic [MID_W-1:0]       mid_in, mid_out;

    wssf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .mid_count   (mid_count),
        .mid_push    (mid_push),
        .mid_wsum    (mid_wsum),
        .mid_col     (mid_col),
        .mid_row     (mid_row),
        .mid_last    (mid_last)
    );

    assign mid_in = {mid_wsum, mid_col, mid_row, mid_last};

    // Queue of selected windows between the front and back parts.
    wssf_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .empty     (mid_empty),
        .count     (mid_count)
    );

    // Back part: weight, bias and saturation.
    logic                 out_push;
    res_t                 out_res, out_head;
    logic [OUT_CNT_W-1:0] out_count;

    wssf_back #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_wsum  (mid_out[MID_W-1 -: WS_W]),
        .mid_col   (mid_out[2*COORD_W:COORD_W+1]),
        .mid_row   (mid_out[COORD_W:1]),
        .mid_last  (mid_out[0]),
        .out_count (out_count),
        .out_push  (out_push),
        .out_res   (out_res)
    );

    // Output queue.
    wssf_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_res),
        .pop       (pop),
        .pop_data  (out_head),
        .empty     (empty),
        .count     (out_count)
    );

    assign pooled_value = out_head.pooled_value;
    assign out_col      = out_head.out_col;
    assign out_row      = out_head.out_row;
    assign plane_done   = out_head.plane_done;

endmodule

// ===== rtl/core/wssf_fifo.sv =====
module wssf_fifo
    import wssf_pkg::*;
#(
    parameter int WIDTH = POOL_W,
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    // A pop on an empty queue is ignored; the writer never pushes into a full one.
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = store_mem[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

// ===== rtl/core/wssf_front.sv =====
module wssf_front
    import wssf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  cfg_t                                             cfg,
    input  logic                                             push,
    output logic                                             full,
    input  logic signed [PIX_W-1:0]                          pixel_value,
    input  logic [MID_CNT_W-1:0]                             mid_count,
    output logic                                             mid_push,
    output logic signed [PIX_W+2*$clog2(MAX_KERNEL)-1:0]     mid_wsum,
    output logic [COORD_W-1:0]                               mid_col,
    output logic [COORD_W-1:0]                               mid_row,
    output logic                                             mid_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HR    = MAX_KERNEL - 1;
    localparam int SW    = (HR > 1) ? $clog2(HR) : 1;
    localparam int CS_W  = PIX_W + $clog2(MAX_KERNEL);
    localparam int WS_W  = PIX_W + 2 * $clog2(MAX_KERNEL);
    localparam int DIM_W = 13;
    localparam int HT_W  = 11;

    // Clamped configuration.
    logic [4:0]       kw, kh;
    logic [3:0]       sx, sy;
    logic [DIM_W-1:0] w;
    logic [HT_W-1:0]  h;

    always_comb
    begin
        kw = (cfg.kernel_width == 4'd0) ? 5'd1 :
             ({1'b0, cfg.kernel_width} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) :
             {1'b0, cfg.kernel_width};
        kh = (cfg.kernel_height == 4'd0) ? 5'd1 :
             ({1'b0, cfg.kernel_height} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) :
             {1'b0, cfg.kernel_height};
        sx = clamp_stride(cfg.stride_x);
        sy = clamp_stride(cfg.stride_y);
        w  = (cfg.image_width == 11'd0) ? DIM_W'(1) :
             (DIM_W'(cfg.image_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) :
             DIM_W'(cfg.image_width);
        h  = (cfg.image_height == 11'd0) ? HT_W'(1) :
             (cfg.image_height > HT_W'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT) :
             cfg.image_height;
    end

    // Raster position counters.
    logic [CW-1:0]      col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic               acc;
    logic [DIM_W-1:0]   col1;
    logic [HT_W-1:0]    row1;
    logic               v1_reg, v2_reg;

    // Admission: the middle queue must hold everything still in the front stages.
    assign full = ((MID_CNT_W+1)'(mid_count) + (MID_CNT_W+1)'(v1_reg)
                   + (MID_CNT_W+1)'(v2_reg)) >= (MID_CNT_W+1)'(MID_DEPTH);
    assign acc  = push && !full;
    assign col1 = DIM_W'(col_reg) + DIM_W'(1);
    assign row1 = HT_W'(row_reg) + HT_W'(1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (acc)
        begin
            if (col1 >= w)
            begin
                col_next = '0;
                if (row1 >= h)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    slot_next = (slot_reg == SW'(HR - 1)) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Classification of the accepted pixel.
    logic              xok0, yok0, xlast0, ylast0;
    logic [CW-1:0]     nx0;
    logic [COORD_W-1:0] ny0;
    logic [HR-1:0]     mask0;
    logic [DIM_W-1:0]  nx0_full, wrem;
    logic [HT_W-1:0]   ny0_full, hrem;

    // The last window is the one whose origin is the final grid point within the image.
    always_comb
    begin
        xok0     = col1 >= DIM_W'(kw);
        nx0_full = col1 - DIM_W'(kw);
        wrem     = w - DIM_W'(kw);
        nx0      = CW'(nx0_full);
        xlast0   = (w >= DIM_W'(kw)) && (nx0_full <= wrem)
                   && ((nx0_full + DIM_W'(sx)) > wrem);
        yok0     = row1 >= HT_W'(kh);
        ny0_full = row1 - HT_W'(kh);
        hrem     = h - HT_W'(kh);
        ny0      = COORD_W'(ny0_full);
        ylast0   = (h >= HT_W'(kh)) && (ny0_full <= hrem)
                   && ((ny0_full + HT_W'(sy)) > hrem);
    end

    // A history bank takes part when its row lies 1 to kh-1 rows back.
    always_comb
    begin
        logic [SW:0] back_rows;
        logic        incl;
        mask0 = '0;
        for (int b = 0; b < HR; b++)
        begin
            if ({1'b0, slot_reg} >= (SW+1)'(b))
            begin
                back_rows = {1'b0, slot_reg} - (SW+1)'(b);
            end
            else
            begin
                back_rows = {1'b0, slot_reg} + (SW+1)'(HR) - (SW+1)'(b);
            end
            if (back_rows == '0)
            begin
                incl = (6'(kh) - 6'd1) >= 6'(HR);
            end
            else
            begin
                incl = 6'(back_rows) <= (6'(kh) - 6'd1);
            end
            mask0[b] = yok0 && incl;
        end
    end

    // Line stores: one bank per history row, written and read at the current column.
    logic signed [PIX_W-1:0] hist_rd_reg [HR];

    for (genvar b = 0; b < HR; b++)
    begin : g_bank
        logic [PIX_W-1:0] hist_mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (acc)
            begin
                if (slot_reg == SW'(b))
                begin
                    hist_mem[col_reg] <= pixel_value;
                end
                hist_rd_reg[b] <= hist_mem[col_reg];
            end
        end
    end

    // First stage registers.
    logic signed [PIX_W-1:0] pix1_reg;
    logic [HR-1:0]           mask1_reg;
    logic                    xok1_reg, yok1_reg, xlast1_reg, ylast1_reg;
    logic [CW-1:0]           nx1_reg;
    logic [COORD_W-1:0]      ny1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pix1_reg   <= pixel_value;
            mask1_reg  <= mask0;
            xok1_reg   <= xok0;
            yok1_reg   <= yok0;
            xlast1_reg <= xlast0;
            ylast1_reg <= ylast0;
            nx1_reg    <= nx0;
            ny1_reg    <= ny0;
        end
    end

    // Column sum and the quotients by the strides.
    logic signed [CS_W-1:0]       colsum1;
    logic [CW+RECIP_W-1:0]        xprod;
    logic [COORD_W+RECIP_W-1:0]   yprod;
    logic [CW-1:0]                qx1;
    logic [COORD_W-1:0]           qy1;

    always_comb
    begin
        colsum1 = CS_W'(pix1_reg);
        for (int b = 0; b < HR; b++)
        begin
            if (mask1_reg[b])
            begin
                colsum1 = colsum1 + CS_W'(hist_rd_reg[b]);
            end
        end
        if (!yok1_reg)
        begin
            colsum1 = '0;
        end
        xprod = (CW+RECIP_W)'(nx1_reg) * (CW+RECIP_W)'(RECIP_TAB[sx]);
        yprod = (COORD_W+RECIP_W)'(ny1_reg) * (COORD_W+RECIP_W)'(RECIP_TAB[sy]);
        qx1   = CW'(xprod >> RECIP_SHIFT);
        qy1   = COORD_W'(yprod >> RECIP_SHIFT);
    end

    // Second stage registers.
    logic signed [CS_W-1:0] colsum2_reg;
    logic [CW-1:0]          qx2_reg, nx2_reg;
    logic [COORD_W-1:0]     qy2_reg, ny2_reg;
    logic                   xok2_reg, yok2_reg, last2_reg;

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            colsum2_reg <= colsum1;
            qx2_reg     <= qx1;
            qy2_reg     <= qy1;
            nx2_reg     <= nx1_reg;
            ny2_reg     <= ny1_reg;
            xok2_reg    <= xok1_reg;
            yok2_reg    <= yok1_reg;
            last2_reg   <= xlast1_reg && ylast1_reg;
        end
    end

    // Column window: the last column sums before the current one.
    logic signed [CS_W-1:0] cw_reg [HR];

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            cw_reg[0] <= colsum2_reg;
            for (int k = 1; k < HR; k++)
            begin
                cw_reg[k] <= cw_reg[k-1];
            end
        end
    end

    // Window sum and the check that the window origin sits on the stride grid.
    logic signed [WS_W-1:0] wsum2;
    logic                   xgrid, ygrid;

    always_comb
    begin
        wsum2 = WS_W'(colsum2_reg);
        for (int k = 0; k < HR; k++)
        begin
            if (5'(k) < (kw - 5'd1))
            begin
                wsum2 = wsum2 + WS_W'(cw_reg[k]);
            end
        end
        xgrid = ((CW+4)'(qx2_reg) * (CW+4)'(sx)) == (CW+4)'(nx2_reg);
        ygrid = ((COORD_W+4)'(qy2_reg) * (COORD_W+4)'(sy)) == (COORD_W+4)'(ny2_reg);
    end

    assign mid_push = v2_reg && xok2_reg && yok2_reg && xgrid && ygrid;
    assign mid_wsum = wsum2;
    assign mid_col  = COORD_W'(qx2_reg);
    assign mid_row  = qy2_reg;
    assign mid_last = last2_reg;

endmodule

// ===== rtl/core/wssf_back.sv =====
module wssf_back
    import wssf_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  cfg_t                                         cfg,
    input  logic                                         mid_empty,
    output logic                                         mid_pop,
    input  logic signed [PIX_W+2*$clog2(MAX_KERNEL)-1:0] mid_wsum,
    input  logic [COORD_W-1:0]                           mid_col,
    input  logic [COORD_W-1:0]                           mid_row,
    input  logic                                         mid_last,
    input  logic [OUT_CNT_W-1:0]                         out_count,
    output logic                                         out_push,
    output res_t                                         out_res
);

    localparam int WS_W  = PIX_W + 2 * $clog2(MAX_KERNEL);
    localparam int PW    = 16 + WS_W;
    localparam int SUM_W = POOL_W + 1;

    logic b1_reg, b2_reg;

    // Take a window sum only when the output queue can hold everything in flight.
    assign mid_pop = !mid_empty &&
                     (((OUT_CNT_W+1)'(out_count) + (OUT_CNT_W+1)'(b1_reg)
                       + (OUT_CNT_W+1)'(b2_reg)) < (OUT_CNT_W+1)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= 1'b0;
            b2_reg <= 1'b0;
        end
        else
        begin
            b1_reg <= mid_pop;
            b2_reg <= b1_reg;
        end
    end

    // Weight multiply.
    logic signed [PW-1:0] prod_reg;
    logic [COORD_W-1:0]   col1_reg, row1_reg;
    logic                 last1_reg;

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            prod_reg  <= PW'(cfg.plane_gain) * PW'(mid_wsum);
            col1_reg  <= mid_col;
            row1_reg  <= mid_row;
            last1_reg <= mid_last;
        end
    end

    // Floor shift, bias add and saturation to 32 bits.
    logic signed [PW-1:0]    scaled;
    logic signed [SUM_W-1:0] biased;
    logic signed [POOL_W-1:0] sat;

    always_comb
    begin
        scaled = prod_reg >>> 12;
        biased = SUM_W'(cfg.plane_offset) + SUM_W'(scaled);
        if (biased[SUM_W-1] == biased[SUM_W-2])
        begin
            sat = POOL_W'(biased);
        end
        else if (biased[SUM_W-1])
        begin
            sat = {1'b1, {(POOL_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(POOL_W-1){1'b1}}};
        end
    end

    res_t res2_reg;

    always_ff @(posedge clk)
    begin
        if (b1_reg)
        begin
            res2_reg.pooled_value <= sat;
            res2_reg.out_col      <= col1_reg;
            res2_reg.out_row      <= row1_reg;
            res2_reg.plane_done   <= last1_reg;
        end
    end

    assign out_push = b2_reg;
    assign out_res  = res2_reg;

endmodule
